// ===== design/btfp_pkg.sv =====
// ----------------------------------------------------------------------------
// btfp_pkg
// Shared constants and types for the byte to frame packer.
// ----------------------------------------------------------------------------
package btfp_pkg;

    localparam int FRAME_BYTES = 8;
    localparam int BYTE_W      = 8;
    localparam int DATA_W      = 64;
    localparam int CNT_W       = 4;
    localparam int IDX_W       = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_IDLE    = 1'b1;
    localparam logic KIND_COMMIT = 1'b0;
    localparam logic KIND_DROP   = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [DATA_W-1:0] frame_data;
        logic [CNT_W-1:0]  byte_count;
        logic              idle_end;
    } result_t;

endpackage

// ===== design/btfp_frame.sv =====
// ----------------------------------------------------------------------------
// btfp_frame
// Open frame store, byte count and frame commit logic for one item.
// ----------------------------------------------------------------------------
module btfp_frame (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic                          pass_mode,
    input  logic                          cmd,
    input  logic [btfp_pkg::BYTE_W-1:0]   rx_byte,
    input  logic                          queue_full,
    output logic                          res_valid,
    output btfp_pkg::result_t             res
);
    import btfp_pkg::*;

    logic [BYTE_W-1:0] bytes_reg [FRAME_BYTES];
    logic [CNT_W-1:0]  held_count_reg;
    logic [CNT_W-1:0]  held_count_next;
    logic              active;
    logic              full_now;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [CNT_W-1:0]  emit_count;
    logic [DATA_W-1:0] emit_data;

    assign active   = step && !pass_mode;
    assign full_now = held_count_reg >= CNT_W'(FRAME_BYTES);

    always_comb
    begin
        res_valid       = 1'b0;
        emit_count      = held_count_reg;
        held_count_next = held_count_reg;
        wr_en           = 1'b0;
        wr_idx          = held_count_reg[IDX_W-1:0];
        if (active)
        begin
            if (cmd == CMD_IDLE)
            begin
                res_valid       = 1'b1;
                held_count_next = '0;
                if (full_now)
                begin
                    emit_count = CNT_W'(FRAME_BYTES);
                end
            end
            else
            begin
                wr_en = 1'b1;
                if (full_now)
                begin
                    // commit the full frame, then open a new one with this byte
                    res_valid       = 1'b1;
                    emit_count      = CNT_W'(FRAME_BYTES);
                    wr_idx          = '0;
                    held_count_next = CNT_W'(1);
                end
                else
                begin
                    held_count_next = held_count_reg + CNT_W'(1);
                end
            end
        end
    end

    // zero the bytes at and above the count
    always_comb
    begin
        emit_data = '0;
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            if (CNT_W'(i) < emit_count)
            begin
                emit_data[BYTE_W*i +: BYTE_W] = bytes_reg[IDX_W'(i)];
            end
        end
    end

    always_comb
    begin
        res.kind       = queue_full ? KIND_DROP : KIND_COMMIT;
        res.frame_data = emit_data;
        res.byte_count = emit_count;
        res.idle_end   = (cmd == CMD_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= '0;
        end
        else
        begin
            held_count_reg <= held_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bytes_reg[wr_idx] <= rx_byte;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg <= CNT_W'(FRAME_BYTES))
        else $error("held byte count above frame size");

    a_idle_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (active && cmd == CMD_IDLE) |=> held_count_reg == '0)
        else $error("idle flush did not empty the frame");

    a_byte_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (active && cmd == CMD_BYTE && !full_now)
        |=> held_count_reg == $past(held_count_reg) + CNT_W'(1))
        else $error("stored byte did not advance the count");

    a_full_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (active && cmd == CMD_BYTE && full_now) |=> held_count_reg == CNT_W'(1))
        else $error("byte after full frame did not open a new frame");

endmodule

// ===== design/btfp_out.sv =====
// ----------------------------------------------------------------------------
// btfp_out
// Result register for the output channel.
// ----------------------------------------------------------------------------
module btfp_out (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  btfp_pkg::result_t             res,
    input  logic                          out_stall,
    output logic                          ready,
    output logic                          out_valid,
    output btfp_pkg::result_t             out_res
);
    import btfp_pkg::*;

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t res_reg;

    // free when empty or when the held result transfers this cycle
    assign ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ready)
        begin
            out_valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

endmodule

// ===== design/byte_to_frame_packer_idle_flush_core.sv =====
// ----------------------------------------------------------------------------
// byte_to_frame_packer_idle_flush_core
// Packs received bytes into frames of up to eight bytes, flushed on idle.
// ----------------------------------------------------------------------------
// One item (a received byte or an idle-line event) is taken per clock when the
// output side keeps up: an item waits in the input register, where the frame
// store and count are updated, and any committed or dropped frame is then
// written to the result register. The sustained rate is one item per cycle,
// limited only by the result register draining. A byte arriving to a full
// frame yields the full frame (idle_end 0); an idle event yields the open
// frame, even an empty one (idle_end 1). kind is 1 when queue_full was set on
// the item that closed the frame. With pass_mode set, items are taken and
// ignored.
module byte_to_frame_packer_idle_flush_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          cmd,
    input  logic [7:0]                    rx_byte,
    input  logic                          queue_full,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          kind,
    output logic [63:0]                   frame_data,
    output logic [3:0]                    byte_count,
    output logic                          idle_end
);
    import btfp_pkg::*;

    logic              pass_mode_reg;
    logic              in_valid_reg;
    logic              in_valid_next;
    logic              cmd_reg;
    logic [BYTE_W-1:0] rx_byte_reg;
    logic              queue_full_reg;
    logic              ready;
    logic              step;
    logic              accept;
    logic              res_valid;
    result_t           res;
    result_t           out_res;

    assign step     = in_valid_reg && ready;
    assign in_stall = in_valid_reg && !ready;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (!in_stall)
        begin
            in_valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_mode_reg <= 1'b0;
            in_valid_reg  <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (cfg_we)
            begin
                pass_mode_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg        <= cmd;
            rx_byte_reg    <= rx_byte;
            queue_full_reg <= queue_full;
        end
    end

    btfp_frame u_frame (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .pass_mode  (pass_mode_reg),
        .cmd        (cmd_reg),
        .rx_byte    (rx_byte_reg),
        .queue_full (queue_full_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    btfp_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && res_valid),
        .res       (res),
        .out_stall (out_stall),
        .ready     (ready),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign kind       = out_res.kind;
    assign frame_data = out_res.frame_data;
    assign byte_count = out_res.byte_count;
    assign idle_end   = out_res.idle_end;

endmodule
